/* design/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* design/met4_pkg.sv */
`default_nettype none

package met4_pkg;

  localparam int unsigned LANES        = 4;
  localparam int unsigned FRAC_BITS    = 28;
  localparam int unsigned Z_W          = 32;
  localparam int unsigned P_W          = 2 * Z_W;
  localparam int unsigned CNT_W        = 16;
  localparam int unsigned THRESH_SHIFT = 2 * FRAC_BITS + 2;
  localparam bit          HAS_THRESH   = (THRESH_SHIFT < P_W);
  localparam logic [P_W-1:0] THRESH    = HAS_THRESH ? (64'd1 << THRESH_SHIFT) : '0;
  localparam logic [CNT_W-1:0] MAX_ITER_RST = 16'd256;

  localparam logic signed [P_W-1:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [P_W-1:0] SAT_LO = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic signed [Z_W-1:0] c_real_0;
    logic signed [Z_W-1:0] c_real_1;
    logic signed [Z_W-1:0] c_real_2;
    logic signed [Z_W-1:0] c_real_3;
    logic signed [Z_W-1:0] c_imag;
  } in_t;

  typedef struct packed {
    logic [CNT_W-1:0] count_0;
    logic [CNT_W-1:0] count_1;
    logic [CNT_W-1:0] count_2;
    logic [CNT_W-1:0] count_3;
  } out_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic mul;
    logic upd;
    logic emit;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic any_pass;
  } status_t;

  function automatic logic signed [Z_W-1:0] sat32(input logic signed [P_W-1:0] v);
    logic signed [Z_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[Z_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[Z_W-1:0];
    end else begin
      r = v[Z_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/met4_ctrl.sv */
`default_nettype none

module met4_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [met4_pkg::CNT_W-1:0] cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  input  wire met4_pkg::status_t         status_i,
  output met4_pkg::cmd_t                 cmd_o
);
  import met4_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_UPD  = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] max_q, max_d;
  logic [CNT_W-1:0] iter_q, iter_d;
  logic             out_valid_q, out_valid_d;
  logic             last_iter;

  assign last_iter = (CNT_W'(iter_q + 1'b1) == max_q);

  always_comb begin
    state_d     = state_q;
    iter_d      = iter_q;
    max_d       = cfg_we_i ? cfg_wdata_i : max_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          iter_d     = '0;
          state_d    = (max_q == '0) ? S_FIN : S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        iter_d    = CNT_W'(iter_q + 1'b1);
        state_d   = (!status_i.any_pass || last_iter) ? S_FIN : S_MUL;
      end
      S_FIN: begin
        // Hold until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      max_q       <= MAX_ITER_RST;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      max_q       <= max_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* design/met4_dp.sv */
`default_nettype none

module met4_dp (
  input  wire logic              clk_i,
  input  wire met4_pkg::in_t     in_data_i,
  input  wire met4_pkg::cmd_t    cmd_i,
  output met4_pkg::status_t      status_o,
  output met4_pkg::out_t         out_data_o
);
  import met4_pkg::*;

  logic signed [Z_W-1:0] cr_q [LANES];
  logic signed [Z_W-1:0] ci_q;
  logic signed [Z_W-1:0] zr_q [LANES];
  logic signed [Z_W-1:0] zi_q [LANES];
  logic signed [P_W-1:0] x2_q [LANES];
  logic signed [P_W-1:0] y2_q [LANES];
  logic signed [P_W-1:0] xy_q [LANES];
  logic [CNT_W-1:0]      cnt_q [LANES];
  logic [LANES-1:0]      alive_q;
  out_t                  out_q;

  logic [LANES-1:0]      pass;
  logic signed [Z_W-1:0] zr_new [LANES];
  logic signed [Z_W-1:0] zi_new [LANES];
  logic [P_W-1:0]        mag [LANES];
  logic signed [P_W-1:0] diff [LANES];

  // Escape test and next z, for all lanes side by side.
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      mag[k]    = unsigned'(x2_q[k]) + unsigned'(y2_q[k]);
      pass[k]   = alive_q[k] && (!HAS_THRESH || (mag[k] < THRESH));
      diff[k]   = x2_q[k] - y2_q[k];
      zr_new[k] = sat32((diff[k] >>> FRAC_BITS) + P_W'(cr_q[k]));
      zi_new[k] = sat32((xy_q[k] >>> (FRAC_BITS - 1)) + P_W'(ci_q));
    end
  end

  assign status_o.any_pass = |pass;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cr_q[0] <= in_data_i.c_real_0;
      cr_q[1] <= in_data_i.c_real_1;
      cr_q[2] <= in_data_i.c_real_2;
      cr_q[3] <= in_data_i.c_real_3;
      ci_q    <= in_data_i.c_imag;
      alive_q <= '1;
    end
    for (int k = 0; k < LANES; k++) begin
      if (cmd_i.load) begin
        zr_q[k]  <= '0;
        zi_q[k]  <= '0;
        cnt_q[k] <= '0;
      end
      if (cmd_i.mul) begin
        x2_q[k] <= P_W'(zr_q[k]) * P_W'(zr_q[k]);
        y2_q[k] <= P_W'(zi_q[k]) * P_W'(zi_q[k]);
        xy_q[k] <= P_W'(zr_q[k]) * P_W'(zi_q[k]);
      end
      if (cmd_i.upd) begin
        alive_q[k] <= pass[k];
        if (pass[k]) begin
          zr_q[k]  <= zr_new[k];
          zi_q[k]  <= zi_new[k];
          cnt_q[k] <= CNT_W'(cnt_q[k] + 1'b1);
        end
      end
    end
    if (cmd_i.emit) begin
      out_q.count_0 <= cnt_q[0];
      out_q.count_1 <= cnt_q[1];
      out_q.count_2 <= cnt_q[2];
      out_q.count_3 <= cnt_q[3];
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

/* design/mandelbrot_escape_time_4lane_unit.sv */
// Channel   Direction  Handshake                 Payload
// cfg       in         cfg_we_i (no wait)        cfg_wdata_i  max_iterations
// in        in         in_valid_i / in_ready_o   in_data_i    four c_real, one c_imag
// out       out        out_valid_o / out_ready_i out_data_o   four counts
//
// Each iteration of all four lanes first forms the products in the lane
// multipliers, then does the escape test and the z update.
// An item runs at most max_iterations iterations (fewer once every lane has
// escaped, none for a zero bound).
// Reset restores max_iterations to 256 and empties the output register.
// A request is taken only while no item is at work; a finished result waits in
// the output register, so the next request can start before it is taken.
`default_nettype none

module mandelbrot_escape_time_4lane_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [met4_pkg::CNT_W-1:0] cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire met4_pkg::in_t              in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output met4_pkg::out_t                  out_data_o
);
  import met4_pkg::*;

  // Command and status between sequencer and lane datapath.
  cmd_t    cmd;
  status_t status;

  // Sequencer: hold the bound register, count iterations, drive handshakes.
  met4_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: four lanes of z registers, products, escape test and counts.
  met4_dp u_dp (
    .clk_i      (clk_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

/* design/met4_chk.sv */
`default_nettype none

`include "assert_macros.svh"

module met4_chk (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       cfg_we_i,
  input wire logic [met4_pkg::CNT_W-1:0] cfg_wdata_i,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire met4_pkg::out_t             out_data_o
);
  import met4_pkg::*;

  logic [CNT_W-1:0] max_q;
  logic             in_acc;
  logic             cnt_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAX_ITER_RST;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  assign in_acc = in_valid_i && in_ready_o;
  assign cnt_ok = (out_data_o.count_0 <= max_q) && (out_data_o.count_1 <= max_q) &&
                  (out_data_o.count_2 <= max_q) && (out_data_o.count_3 <= max_q);

  // A stalled result stays put.
  `ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  // No count exceeds the iteration bound.
  `ASSERT_IMPL(a_cnt_bound, out_valid_o, cnt_ok)
  // The unit is busy right after taking a request.
  `ASSERT_NEXT(a_busy, in_acc, !in_ready_o)
  // No result appears in the cycle after a request is taken.
  `ASSERT_NEXT(a_no_early, in_acc, !$rose(out_valid_o))

endmodule

bind mandelbrot_escape_time_4lane_unit met4_chk u_chk (.*);

`default_nettype wire

/* dv/tb_mandelbrot_escape_time_4lane_unit.sv */
`timescale 1ns / 1ps

module tb_mandelbrot_escape_time_4lane_unit;
  import met4_pkg::*;

  // Q4.28 handy values
  localparam int FX_ONE = 1 << FRAC_BITS;
  localparam int FX_TWO = 2 * FX_ONE;

  // Escape threshold: 4.0 with 2*FRAC_BITS fraction bits, if it fits in 64 bits
  localparam int unsigned    ESC_SHIFT = 2 * FRAC_BITS + 2;
  localparam bit             ESC_ON    = (ESC_SHIFT < 64);
  localparam longint unsigned ESC_LIMIT = ESC_ON ? (64'd1 << (ESC_ON ? ESC_SHIFT : 0)) : 64'd0;

  // Length of the long receiver hold-off, in cycles
  localparam int HOLD_OFF_CYCLES = 3000;

  // Holds the counts still owed by the block, oldest first, and works out
  // new ones from each accepted request.
  class escape_count_board;
    out_t        pending_counts[$];
    int unsigned bound;
    int          faults;

    function new();
      bound  = MAX_ITER_RST;
      faults = 0;
    endfunction

    static function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function out_t escape_counts(in_t req);
      longint          re[LANES];
      longint          im[LANES];
      longint          cr[LANES];
      longint          ci;
      longint          x2;
      longint          y2;
      longint          xy;
      longint unsigned mag;
      bit              alive[LANES];
      bit              any;
      int unsigned     cnt[LANES];
      out_t            res;
      cr[0] = req.c_real_0;
      cr[1] = req.c_real_1;
      cr[2] = req.c_real_2;
      cr[3] = req.c_real_3;
      ci    = req.c_imag;
      for (int k = 0; k < LANES; k++) begin
        re[k]    = 0;
        im[k]    = 0;
        cnt[k]   = 0;
        alive[k] = 1'b1;
      end
      for (int unsigned iter = 0; iter < bound; iter++) begin
        any = 1'b0;
        for (int k = 0; k < LANES; k++) begin
          if (alive[k]) begin
            x2  = re[k] * re[k];
            y2  = im[k] * im[k];
            xy  = re[k] * im[k];
            mag = x2 + y2;
            if (ESC_ON && mag >= ESC_LIMIT) begin
              alive[k] = 1'b0;
            end else begin
              re[k] = clamp32(((x2 - y2) >>> FRAC_BITS) + cr[k]);
              im[k] = clamp32((xy >>> (FRAC_BITS - 1)) + ci);
              any   = 1'b1;
            end
          end
        end
        if (!any) break;
        for (int k = 0; k < LANES; k++) begin
          if (alive[k]) cnt[k]++;
        end
      end
      res.count_0 = cnt[0][CNT_W-1:0];
      res.count_1 = cnt[1][CNT_W-1:0];
      res.count_2 = cnt[2][CNT_W-1:0];
      res.count_3 = cnt[3][CNT_W-1:0];
      return res;
    endfunction

    function void note_request(in_t req);
      pending_counts.push_back(escape_counts(req));
    endfunction

    function void check_counts(out_t got);
      out_t want;
      if (pending_counts.size() == 0) begin
        faults++;
        if (faults <= 10) $display("unexpected result: counts %0d %0d %0d %0d",
                                   got.count_0, got.count_1, got.count_2, got.count_3);
        return;
      end
      want = pending_counts.pop_front();
      if (got.count_0 !== want.count_0 || got.count_1 !== want.count_1 ||
          got.count_2 !== want.count_2 || got.count_3 !== want.count_3) begin
        faults++;
        if (faults <= 10)
          $display("count mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                   want.count_0, want.count_1, want.count_2, want.count_3,
                   got.count_0, got.count_1, got.count_2, got.count_3);
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CNT_W-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_ready_o;
  in_t              in_data_i;
  logic             out_valid_o;
  logic             out_ready_i;
  out_t             out_data_o;

  escape_count_board board;
  in_t               request_queue[$];
  bit                hold_off_request = 1'b0;

  mandelbrot_escape_time_4lane_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // 4 ns clock
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Build one request from four real parts and the shared imaginary part.
  function automatic in_t make_request(int r0, int r1, int r2, int r3, int ci);
    in_t r;
    r.c_real_0 = r0;
    r.c_real_1 = r1;
    r.c_real_2 = r2;
    r.c_real_3 = r3;
    r.c_imag   = ci;
    return r;
  endfunction

  // Random request. Most land in the window around the set, where counts get
  // interesting; some hug the known boundary points; the rest is pure noise
  // across the whole 32-bit range, which also toggles every payload bit.
  function automatic in_t random_request();
    int pick;
    int base;
    int stride;
    int centre;
    int v[5];
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      for (int k = 0; k < 5; k++) v[k] = $urandom;
    end else if (pick < 40) begin
      for (int k = 0; k < 4; k++) begin
        case ($urandom_range(0, 4))
          0:       centre = -FX_TWO;
          1:       centre = FX_ONE / 4;
          2:       centre = -(3 * FX_ONE / 4);
          3:       centre = -(7 * FX_ONE / 4);
          default: centre = 0;
        endcase
        v[k] = centre + int'($urandom_range(0, 131072)) - 65536;
      end
      v[4] = int'($urandom_range(0, 131072)) - 65536;
    end else if (pick < 70) begin
      for (int k = 0; k < 4; k++) v[k] = int'($urandom_range(0, 32'h3000_0000)) - 32'h2400_0000;
      v[4] = int'($urandom_range(0, 32'h3000_0000)) - 32'h1800_0000;
    end else begin
      // neighbouring pixels along one row
      base   = int'($urandom_range(0, 32'h3000_0000)) - 32'h2400_0000;
      stride = $urandom_range(1, FX_ONE / 32);
      for (int k = 0; k < 4; k++) v[k] = base + k * stride;
      v[4] = int'($urandom_range(0, 32'h3000_0000)) - 32'h1800_0000;
    end
    return make_request(v[0], v[1], v[2], v[3], v[4]);
  endfunction

  task automatic queue_random(int n);
    repeat (n) request_queue.push_back(random_request());
  endtask

  // Write the bound while the block is idle; starts and ends on a rising edge.
  task automatic write_bound(logic [CNT_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    board.bound = value;
  endtask

  // Offer every queued request in bursts with random gaps. Valid is held with
  // the payload steady until the block takes the request.
  task automatic send_requests();
    int   burst_left;
    int   gap_left;
    in_t  next;
    burst_left = $urandom_range(1, 10);
    gap_left   = 0;
    while (request_queue.size() != 0) begin
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left--;
        @(posedge clk_i);
      end else begin
        next = request_queue.pop_front();
        in_valid_i <= 1'b1;
        in_data_i  <= next;
        do @(posedge clk_i); while (!in_ready_o);
        board.note_request(next);
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 10);
          // mostly short gaps, now and then one long enough to span an item
          case ($urandom_range(0, 9))
            0, 1, 2, 3: gap_left = 0;
            4, 5, 6, 7: gap_left = $urandom_range(1, 6);
            8:          gap_left = $urandom_range(7, 40);
            default:    gap_left = $urandom_range(41, 400);
          endcase
        end
      end
    end
    in_valid_i <= 1'b0;
  endtask

  // Every request yields one result, so the block is idle once nothing is
  // owed; allow a few cycles of margin anyway.
  task automatic wait_idle();
    while (board.pending_counts.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Receiver: stall on a rotating ready pattern that changes every so often,
  // and drop ready for a long stretch on request from the main sequence.
  initial begin
    int          window_left;
    int          stall_left;
    int          slot;
    logic [15:0] ready_pattern;
    out_ready_i   = 1'b0;
    window_left   = 0;
    stall_left    = 0;
    slot          = 0;
    ready_pattern = 16'hFFFF;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        stall_left       = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (window_left == 0) begin
          window_left = $urandom_range(16, 200);
          case ($urandom_range(0, 3))
            0:       ready_pattern = 16'hFFFF;
            1:       ready_pattern = 16'($urandom) | 16'h0001;
            2:       ready_pattern = 16'h0101;
            default: ready_pattern = 16'h5A5A;
          endcase
        end
        window_left--;
        out_ready_i <= ready_pattern[slot];
        slot = (slot + 1) % 16;
      end
    end
  end

  // Check each result as it is taken.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_counts(out_data_o);
  end

  // Main sequence
  initial begin
    board       = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests at the reset bound of 256.
    // z stays at zero forever: every lane runs to the bound
    request_queue.push_back(make_request(0, 0, 0, 0, 0));
    // field extremes
    request_queue.push_back(make_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                         32'h7FFF_FFFF, 32'h7FFF_FFFF));
    request_queue.push_back(make_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                         32'h8000_0000, 32'h8000_0000));
    request_queue.push_back(make_request(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h7FFF_FFFF,
                                         32'h8000_0000));
    request_queue.push_back(make_request(32'h8000_0000, 32'h7FFF_FFFF, -1, 1,
                                         32'h7FFF_FFFF));
    // |z|^2 lands exactly on 4.0: the lane must escape, not carry on
    request_queue.push_back(make_request(-FX_TWO, -FX_TWO, -FX_TWO, -FX_TWO, 0));
    request_queue.push_back(make_request(0, 0, 0, 0, FX_TWO));
    request_queue.push_back(make_request(-FX_TWO + 1, -FX_TWO - 1, FX_TWO - 1, FX_TWO, 0));
    // cusp, period-two bulb, and the point i
    request_queue.push_back(make_request(FX_ONE / 4, -(3 * FX_ONE / 4), -FX_ONE, 0, 0));
    request_queue.push_back(make_request(0, 0, 0, 0, FX_ONE));
    // just outside the cusp: long but finite counts
    request_queue.push_back(make_request(FX_ONE / 4 + (1 << 16), FX_ONE / 4 + (1 << 20),
                                         -(3 * FX_ONE / 4), -(7 * FX_ONE / 4), 1 << 16));
    // lanes escape at different times; early ones must freeze
    request_queue.push_back(make_request(0, -FX_TWO, FX_ONE / 4, FX_TWO, 0));
    request_queue.push_back(make_request(-FX_ONE, FX_ONE / 3, -FX_ONE / 10, FX_ONE / 2,
                                         7 * FX_ONE / 10));
    request_queue.push_back(make_request(-FX_ONE / 2, FX_ONE / 2, -FX_ONE, FX_ONE / 8,
                                         -(FX_ONE / 2)));
    // negative products exercise round toward minus infinity
    request_queue.push_back(make_request(-1, -3, 3, 1, -7));
    request_queue.push_back(make_request(-FX_ONE / 3, -(FX_ONE / 7), FX_ONE / 5,
                                         -(FX_ONE / 9), -(FX_ONE / 3)));
    queue_random(4);
    send_requests();
    wait_idle();

    // Bound of one: a single iteration for every lane.
    write_bound(16'd1);
    request_queue.push_back(make_request(0, -FX_TWO, 32'h8000_0000, 32'h7FFF_FFFF, 0));
    queue_random(20);
    send_requests();
    wait_idle();

    // Zero bound: no iteration runs, every count is zero.
    write_bound(16'd0);
    request_queue.push_back(make_request(0, 0, 0, 0, 0));
    request_queue.push_back(make_request(32'h8000_0000, 32'h7FFF_FFFF, -FX_TWO, FX_ONE, 0));
    queue_random(3);
    send_requests();
    wait_idle();

    // Largest bound: keep to two requests, one of which runs the full length.
    write_bound(16'hFFFF);
    request_queue.push_back(make_request(0, FX_ONE / 4, -FX_ONE, FX_ONE / 4 + (1 << 12), 0));
    request_queue.push_back(make_request(-FX_TWO, FX_ONE / 4 + (1 << 14), FX_ONE, FX_ONE / 2,
                                         FX_ONE / 2));
    send_requests();
    wait_idle();

    // Short items and a long receiver hold-off: the output register fills and
    // the block has to refuse further requests until the results drain.
    write_bound(16'd20);
    hold_off_request = 1'b1;
    queue_random(40);
    send_requests();
    wait_idle();

    // Random phases, one of them back at the reset value.
    for (int phase = 0; phase < 4; phase++) begin
      write_bound(phase == 1 ? 16'd256 : 16'($urandom_range(2, 300)));
      queue_random(115);
      send_requests();
      wait_idle();
    end

    // Catch any stray result before deciding.
    repeat (40) @(posedge clk_i);
    if (board.faults == 0 && board.pending_counts.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Give up well beyond the slowest legitimate run.
  initial begin
    #15_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/met4_pkg.sv
design/met4_ctrl.sv
design/met4_dp.sv
design/mandelbrot_escape_time_4lane_unit.sv
design/met4_chk.sv
dv/tb_mandelbrot_escape_time_4lane_unit.sv
